// ----- hdl/pltw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page table walker package
// Shared types, codes and address masks for the four-level page table walker.
// ----------------------------------------------------------------------------
package pltw_pkg;

    // Physical address bits that the platform implements (32 to 52).
    localparam int PHYS_ADDR_BITS = 52;

    // Fixed field widths.
    localparam int PA_W      = 52;
    localparam int VA_W      = 48;
    localparam int ENTRY_W   = 64;
    localparam int BITPOS_W  = 6;
    localparam int CFG_IDX_W = 4;
    localparam int VPN_W     = 9;
    localparam int ENTRY_SZ_W = 3;

    // Page offset widths for 4 KiB, 2 MiB and 1 GiB pages.
    localparam int OFF_4K_W = 12;
    localparam int OFF_2M_W = 21;
    localparam int OFF_1G_W = 30;

    typedef logic [PA_W-1:0]      t_pa;
    typedef logic [VA_W-1:0]      t_va;
    typedef logic [ENTRY_W-1:0]   t_entry;
    typedef logic [BITPOS_W-1:0]  t_bitpos;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [VPN_W-1:0]     t_vpn;
    typedef logic [1:0]           t_level;

    localparam t_pa PA_MASK = PA_W'((65'(1) << PHYS_ADDR_BITS) - 65'(1));
    localparam t_pa FRAME_4K_MASK = PA_MASK & ~((t_pa'(1) << OFF_4K_W) - t_pa'(1));
    localparam t_pa FRAME_2M_MASK = PA_MASK & ~((t_pa'(1) << OFF_2M_W) - t_pa'(1));
    localparam t_pa FRAME_1G_MASK = PA_MASK & ~((t_pa'(1) << OFF_1G_W) - t_pa'(1));

    // Walk levels.
    localparam t_level LVL_TOP  = 2'd0;
    localparam t_level LVL_PDPT = 2'd1;
    localparam t_level LVL_PD   = 2'd2;
    localparam t_level LVL_PT   = 2'd3;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_VALID_POS = 4'd0;
    localparam t_cfg_idx CFG_LARGE_POS = 4'd1;

    localparam t_bitpos VALID_POS_RST = 6'd0;
    localparam t_bitpos LARGE_POS_RST = 6'd7;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_ENTRY = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2,
        KIND_RDERR = 2'd3
    } t_kind;

    typedef struct packed {
        t_bitpos valid_pos;
        t_bitpos large_pos;
    } t_cfg;

    typedef struct packed {
        logic   busy;
        t_level level;
        t_va    vaddr;
    } t_walk_state;

    typedef struct packed {
        t_func  func;
        t_pa    root_addr;
        t_va    virt_addr;
        t_entry entry;
        logic   read_error;
    } t_item;

    typedef struct packed {
        t_kind  kind;
        t_pa    read_addr;
        t_pa    phys_addr;
        t_level fault_level;
    } t_result;

    typedef struct packed {
        logic    has_result;
        t_result result;
    } t_step;

endpackage
`default_nettype wire

// ----- hdl/pltw_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Walker input channel
// Valid/ready channel carrying start requests and returned table entries.
// ----------------------------------------------------------------------------
interface pltw_in_if import pltw_pkg::*; ();
    logic   valid;
    logic   ready;
    t_func  func;
    t_pa    root_addr;
    t_va    virt_addr;
    t_entry entry;
    logic   read_error;

    modport source (output valid, output func, output root_addr, output virt_addr,
                    output entry, output read_error, input ready);
    modport sink   (input valid, input func, input root_addr, input virt_addr,
                    input entry, input read_error, output ready);
endinterface
`default_nettype wire

// ----- hdl/pltw_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Walker result channel
// Valid/ready channel carrying read requests, translations and faults.
// ----------------------------------------------------------------------------
interface pltw_out_if import pltw_pkg::*; ();
    logic   valid;
    logic   ready;
    t_kind  kind;
    t_pa    read_addr;
    t_pa    phys_addr;
    t_level fault_level;

    modport source (output valid, output kind, output read_addr, output phys_addr,
                    output fault_level, input ready);
    modport sink   (input valid, input kind, input read_addr, input phys_addr,
                    input fault_level, output ready);
endinterface
`default_nettype wire

// ----- hdl/pltw_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Walker configuration channel
// Valid/ready register write channel with index and data.
// ----------------------------------------------------------------------------
interface pltw_cfg_if import pltw_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_bitpos  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/four_level_page_table_walker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Four-level page table walker
// Translates 48-bit virtual addresses through four levels of page tables.
// ----------------------------------------------------------------------------
// The walker takes one transfer per clock on its input channel. A start
// transfer (func = start) carries the root table address and the virtual
// address; the walker answers with a read request (kind = read) for the top
// table entry. Each entry transfer (func = entry) carries the 64-bit entry that
// memory returned, or a read error, and is answered with the next read
// request, the translated physical address (kind = done, 4 KiB, 2 MiB or
// 1 GiB page), an invalid entry fault or a read error, with the level of the
// entry concerned. A start while a walk is in flight abandons that walk. An
// entry transfer while no walk is in flight is dropped without a result.
// Each item passes an input register and then a result register, and its
// result is offered from the result register. A new item is taken every
// clock as long as the result channel keeps up; the result register is the
// only thing that holds the input back. Configuration writes (valid bit and
// large-page bit positions) are always accepted and should be made while no
// walk is in flight.
// ----------------------------------------------------------------------------
module four_level_page_table_walker import pltw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pltw_in_if.sink     i_req,
    pltw_out_if.source  o_rsp,
    pltw_cfg_if.sink    i_cfg
);

    t_cfg        cfg;

    // Input register stage.
    logic        r_s1_valid;
    t_item       r_s1_item;
    logic        s1_advance;
    logic        in_fire;

    // Walk state, updated as each item leaves the input register.
    t_walk_state r_state;
    t_walk_state n_state;
    t_step       step;

    // Result register.
    logic        r_out_valid;
    t_result     r_out;
    logic        out_fire;

    pltw_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    pltw_step u_step (
        .i_item  (r_s1_item),
        .i_state (r_state),
        .i_cfg   (cfg),
        .o_state (n_state),
        .o_step  (step)
    );

    // The held item moves on when its result has room, or when it has no
    // result at all (an entry arriving while idle).
    assign out_fire    = r_out_valid && o_rsp.ready;
    assign s1_advance  = r_s1_valid && (!r_out_valid || o_rsp.ready || !step.has_result);
    assign i_req.ready = !r_s1_valid || s1_advance;
    assign in_fire     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item.func       <= i_req.func;
            r_s1_item.root_addr  <= i_req.root_addr;
            r_s1_item.virt_addr  <= i_req.virt_addr;
            r_s1_item.entry      <= i_req.entry;
            r_s1_item.read_error <= i_req.read_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s1_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance && step.has_result) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && step.has_result) begin
            r_out <= step.result;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.kind        = r_out.kind;
    assign o_rsp.read_addr   = r_out.read_addr;
    assign o_rsp.phys_addr   = r_out.phys_addr;
    assign o_rsp.fault_level = r_out.fault_level;

    // A start always leaves a walk in flight.
    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance && r_s1_item.func == FUNC_START |=> r_state.busy)
        else $error("walk not in flight after start");

    // Any terminal result ends the walk.
    a_terminal_clears_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance && step.has_result && step.result.kind != KIND_READ |=> !r_state.busy)
        else $error("walk still in flight after terminal result");

    // An entry while idle produces nothing.
    a_idle_entry_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_item.func == FUNC_ENTRY && !r_state.busy |-> !step.has_result)
        else $error("result produced for entry while idle");

    // Entry reads are always 8-byte aligned.
    a_read_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_READ |-> r_out.read_addr[ENTRY_SZ_W-1:0] == '0)
        else $error("misaligned entry read request");

    // A returned entry that leads to another read moves one level down.
    a_level_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance && r_s1_item.func == FUNC_ENTRY && step.has_result
        && step.result.kind == KIND_READ
        |=> r_state.level == $past(r_state.level) + 2'd1)
        else $error("walk level did not advance");

endmodule
`default_nettype wire

// ----- hdl/pltw_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Walker configuration registers
// Holds the valid and large-page bit positions used to decode entries.
// ----------------------------------------------------------------------------
module pltw_cfg_regs import pltw_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pltw_cfg_if.sink        i_cfg,
    output t_cfg            o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are always taken; unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_VALID_POS: n_cfg.valid_pos = i_cfg.data;
                CFG_LARGE_POS: n_cfg.large_pos = i_cfg.data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.valid_pos <= VALID_POS_RST;
            r_cfg.large_pos <= LARGE_POS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- hdl/pltw_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Walker step logic
// Decodes one item against the walk state and forms the next state and result.
// ----------------------------------------------------------------------------
module pltw_step import pltw_pkg::*; (
    input  t_item       i_item,
    input  t_walk_state i_state,
    input  t_cfg        i_cfg,
    output t_walk_state o_state,
    output t_step       o_step
);

    function automatic t_vpn va_index(input t_va vaddr, input t_level lvl);
        t_vpn idx;
        case (lvl)
            LVL_TOP:  idx = vaddr[47:39];
            LVL_PDPT: idx = vaddr[38:30];
            LVL_PD:   idx = vaddr[29:21];
            default:  idx = vaddr[20:12];
        endcase
        return idx;
    endfunction

    // The table frame is 4 KiB aligned, so adding index times eight is a plain merge.
    function automatic t_pa entry_addr(input t_pa table_base, input t_vpn idx);
        t_pa a;
        a = (table_base & FRAME_4K_MASK)
            | (t_pa'(idx) << ENTRY_SZ_W);
        return a & PA_MASK;
    endfunction

    logic   entry_valid;
    logic   entry_large;
    t_pa    entry_pa;
    t_level next_level;

    assign entry_valid = i_item.entry[i_cfg.valid_pos];
    assign entry_large = i_item.entry[i_cfg.large_pos];
    assign entry_pa    = i_item.entry[PA_W-1:0];
    assign next_level  = i_state.level + 2'd1;

    always_comb begin
        o_state = i_state;
        o_step  = '0;
        if (i_item.func == FUNC_START) begin
            // A start always replaces whatever walk was in flight.
            o_state.busy  = 1'b1;
            o_state.level = LVL_TOP;
            o_state.vaddr = i_item.virt_addr;
            o_step.has_result         = 1'b1;
            o_step.result.kind        = KIND_READ;
            o_step.result.read_addr   = entry_addr(i_item.root_addr,
                                                   va_index(i_item.virt_addr, LVL_TOP));
            o_step.result.fault_level = LVL_TOP;
        end else if (i_state.busy) begin
            o_step.has_result = 1'b1;
            if (i_item.read_error) begin
                o_state.busy              = 1'b0;
                o_step.result.kind        = KIND_RDERR;
                o_step.result.fault_level = i_state.level;
            end else if (!entry_valid) begin
                o_state.busy              = 1'b0;
                o_step.result.kind        = KIND_FAULT;
                o_step.result.fault_level = i_state.level;
            end else if (i_state.level == LVL_PDPT && entry_large) begin
                o_state.busy            = 1'b0;
                o_step.result.kind      = KIND_DONE;
                o_step.result.phys_addr = (entry_pa & FRAME_1G_MASK)
                                          | t_pa'(i_state.vaddr[OFF_1G_W-1:0]);
            end else if (i_state.level == LVL_PD && entry_large) begin
                o_state.busy            = 1'b0;
                o_step.result.kind      = KIND_DONE;
                o_step.result.phys_addr = (entry_pa & FRAME_2M_MASK)
                                          | t_pa'(i_state.vaddr[OFF_2M_W-1:0]);
            end else if (i_state.level == LVL_PT) begin
                o_state.busy            = 1'b0;
                o_step.result.kind      = KIND_DONE;
                o_step.result.phys_addr = (entry_pa & FRAME_4K_MASK)
                                          | t_pa'(i_state.vaddr[OFF_4K_W-1:0]);
            end else begin
                o_state.level             = next_level;
                o_step.result.kind        = KIND_READ;
                o_step.result.read_addr   = entry_addr(entry_pa,
                                                       va_index(i_state.vaddr, next_level));
                o_step.result.fault_level = next_level;
            end
        end
    end

endmodule
`default_nettype wire

// ----- tb/four_level_page_table_walker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walker testbench
// Feeds start requests and returned table entries into the walker, predicts
// every read request, translation and fault from its own model of the walk,
// and checks each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_tb;
    import pltw_pkg::*;

    localparam int    HALF_PERIOD  = 5;
    localparam int    RESET_CYCLES = 12;
    localparam int    TARGET_ITEMS = 450;
    // An ignored entry is held only in the input register, so these quiet
    // cycles are enough for it to leave the pipeline.
    localparam int    SETTLE_CYCLES = 4;
    localparam int    TAIL_CYCLES   = 8;
    localparam int    CYCLE_LIMIT   = 400000;
    localparam t_pa   PA_KEEP = t_pa'((65'd1 << PHYS_ADDR_BITS) - 65'd1);

    typedef enum logic [1:0] {
        ACT_ITEM,
        ACT_REG,
        ACT_DRAIN
    } t_stim_act;

    // One entry of the stimulus script: an input item, a register write, or
    // a pause until the walker has delivered everything that is pending.
    typedef struct {
        t_stim_act act;
        t_item     item;
        t_cfg_idx  reg_idx;
        t_bitpos   reg_val;
        bit        steady;
    } t_stim_step;

    logic i_clk;
    logic i_rst_n;

    pltw_in_if  req_ch ();
    pltw_out_if rsp_ch ();
    pltw_cfg_if cfg_ch ();

    four_level_page_table_walker u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // Stimulus script, predicted results and the handshake flags that the
    // monitor hands to the driver.
    t_stim_step stim_steps[$];
    t_result    pending_walk_results[$];
    bit         req_took;
    bit         cfg_took;
    int         quiet_cycles;
    int         cycle_count;
    int         error_count;

    // Model of the walker as the hardware should see it.
    logic    walk_busy;
    t_level  walk_lvl;
    t_va     walk_va;
    t_bitpos pos_valid;
    t_bitpos pos_large;

    // The generator's view of the register settings, so that it can build
    // entries with the flags it wants.
    t_bitpos gen_vpos;
    t_bitpos gen_lpos;
    int      gen_count;

    // Driver state.
    int send_gap;
    int rsp_stall;
    bit steady;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #HALF_PERIOD i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Physical frame of a table entry or a page, with the low bits cleared.
    function automatic t_pa frame_at(input t_entry e, input int low_bits);
        return t_pa'(e) & PA_KEEP & ~((t_pa'(1) << low_bits) - t_pa'(1));
    endfunction

    // Address of the entry for the current level inside the given table.
    function automatic t_pa entry_addr(input t_pa tbl_base);
        t_pa idx;
        idx = t_pa'((walk_va >> (39 - 9 * int'(walk_lvl))) & 48'h1FF);
        return (tbl_base + (idx << 3)) & PA_KEEP;
    endfunction

    // Advances the model by one accepted input item. Returns 1 when the item
    // causes a result, which is then placed in res.
    function automatic bit predict_walk(input t_item it, output t_result res);
        bit is_large;
        res = '0;
        if (it.func == FUNC_START) begin
            // A start always begins a fresh walk, abandoning any current one.
            walk_busy     = 1'b1;
            walk_lvl      = LVL_TOP;
            walk_va       = it.virt_addr;
            res.kind      = KIND_READ;
            res.read_addr = entry_addr(frame_at(t_entry'(it.root_addr), OFF_4K_W));
            res.fault_level = walk_lvl;
            return 1'b1;
        end
        // An entry that arrives with no walk in flight is dropped.
        if (!walk_busy) begin
            return 1'b0;
        end
        if (it.read_error) begin
            walk_busy       = 1'b0;
            res.kind        = KIND_RDERR;
            res.fault_level = walk_lvl;
            return 1'b1;
        end
        if (!it.entry[pos_valid]) begin
            walk_busy       = 1'b0;
            res.kind        = KIND_FAULT;
            res.fault_level = walk_lvl;
            return 1'b1;
        end
        // The page-size flag only counts at the directory pointer and
        // directory levels; at the top and table levels it is ignored.
        is_large = it.entry[pos_large];
        if (walk_lvl == LVL_PDPT && is_large) begin
            walk_busy     = 1'b0;
            res.kind      = KIND_DONE;
            res.phys_addr = frame_at(it.entry, OFF_1G_W) | t_pa'(walk_va[OFF_1G_W-1:0]);
            return 1'b1;
        end
        if (walk_lvl == LVL_PD && is_large) begin
            walk_busy     = 1'b0;
            res.kind      = KIND_DONE;
            res.phys_addr = frame_at(it.entry, OFF_2M_W) | t_pa'(walk_va[OFF_2M_W-1:0]);
            return 1'b1;
        end
        if (walk_lvl == LVL_PT) begin
            walk_busy     = 1'b0;
            res.kind      = KIND_DONE;
            res.phys_addr = frame_at(it.entry, OFF_4K_W) | t_pa'(walk_va[OFF_4K_W-1:0]);
            return 1'b1;
        end
        walk_lvl        = walk_lvl + 2'd1;
        res.kind        = KIND_READ;
        res.read_addr   = entry_addr(frame_at(it.entry, OFF_4K_W));
        res.fault_level = walk_lvl;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap(input bit no_idle);
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic push_item(input t_func f, input t_pa root, input t_va va,
                             input t_entry e, input logic err, input bit counted);
        t_stim_step s;
        s = '{act: ACT_ITEM, item: '0, reg_idx: CFG_VALID_POS, reg_val: '0, steady: 1'b0};
        s.item.func       = f;
        s.item.root_addr  = root;
        s.item.virt_addr  = va;
        s.item.entry      = e;
        s.item.read_error = err;
        stim_steps.push_back(s);
        if (counted) begin
            gen_count++;
        end
    endtask

    task automatic push_reg(input t_cfg_idx idx, input t_bitpos val);
        t_stim_step s;
        s = '{act: ACT_REG, item: '0, reg_idx: idx, reg_val: val, steady: 1'b0};
        stim_steps.push_back(s);
        if (idx == CFG_VALID_POS) begin
            gen_vpos = val;
        end else begin
            gen_lpos = val;
        end
    endtask

    task automatic push_drain(input bit no_idle);
        t_stim_step s;
        s = '{act: ACT_DRAIN, item: '0, reg_idx: CFG_VALID_POS, reg_val: '0,
              steady: no_idle};
        stim_steps.push_back(s);
    endtask

    // Random entry with the valid and page-size flags forced. The valid flag
    // is set last so that it wins when both flags share one bit.
    function automatic t_entry build_entry(input bit valid_set, input bit large_set);
        t_entry e;
        e           = rand64();
        e[gen_lpos] = large_set;
        e[gen_vpos] = valid_set;
        return e;
    endfunction

    // One walk with random content: a start, then entries level by level,
    // ending in a translation, a fault, a read error or an abandoned walk.
    task automatic add_walk();
        t_entry e;
        int     r;
        push_item(FUNC_START, t_pa'(rand64()), t_va'(rand64()), rand64(),
                  1'($urandom), 1'b1);
        for (int lvl = 0; lvl < 4; lvl++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                return;
            end
            if (r < 9) begin
                push_item(FUNC_ENTRY, t_pa'(rand64()), t_va'(rand64()), rand64(), 1'b1, 1'b1);
                return;
            end
            if (r < 16) begin
                push_item(FUNC_ENTRY, t_pa'(rand64()), t_va'(rand64()),
                          build_entry(1'b0, 1'($urandom)), 1'b0, 1'b1);
                return;
            end
            if (lvl == 1 || lvl == 2) begin
                e = build_entry(1'b1, $urandom_range(0, 3) == 0);
            end else begin
                e = build_entry(1'b1, 1'($urandom));
            end
            push_item(FUNC_ENTRY, t_pa'(rand64()), t_va'(rand64()), e, 1'b0, 1'b1);
            if ((lvl == 1 || lvl == 2) && e[gen_lpos]) begin
                return;
            end
        end
    endtask

    task automatic build_stimulus();
        t_bitpos vsel;
        t_bitpos lsel;
        int      walks;
        int      phase;
        gen_vpos  = VALID_POS_RST;
        gen_lpos  = LARGE_POS_RST;
        gen_count = 0;

        // Directed part, with the register values left at reset.
        // All-ones entries: the page-size flag is ignored at the top level,
        // then ends the walk with a 1 GiB page one level down.
        push_item(FUNC_START, '1, '1, '0, 1'b0, 1'b1);
        push_item(FUNC_ENTRY, '0, '0, '1, 1'b0, 1'b1);
        push_item(FUNC_ENTRY, '0, '0, '1, 1'b0, 1'b1);
        // All-zero addresses down to a 2 MiB page.
        push_item(FUNC_START, '0, '0, '0, 1'b0, 1'b1);
        push_item(FUNC_ENTRY, '0, '0, 64'h1, 1'b0, 1'b1);
        push_item(FUNC_ENTRY, '0, '0, 64'h1, 1'b0, 1'b1);
        push_item(FUNC_ENTRY, '0, '0, 64'h81, 1'b0, 1'b1);
        // Full four-level walk; the page-size flag at the table level is ignored.
        push_item(FUNC_START, t_pa'(rand64()), t_va'(rand64()), '0, 1'b0, 1'b1);
        push_item(FUNC_ENTRY, '0, '0, build_entry(1'b1, 1'b0), 1'b0, 1'b1);
        push_item(FUNC_ENTRY, '0, '0, build_entry(1'b1, 1'b0), 1'b0, 1'b1);
        push_item(FUNC_ENTRY, '0, '0, build_entry(1'b1, 1'b0), 1'b0, 1'b1);
        push_item(FUNC_ENTRY, '0, '0, build_entry(1'b1, 1'b1), 1'b0, 1'b1);
        // Invalid top-level entry, all other bits set.
        push_item(FUNC_START, t_pa'(rand64()), t_va'(rand64()), '0, 1'b0, 1'b1);
        push_item(FUNC_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b1);
        // Read error at the directory pointer level.
        push_item(FUNC_START, t_pa'(rand64()), t_va'(rand64()), '0, 1'b0, 1'b1);
        push_item(FUNC_ENTRY, '0, '0, build_entry(1'b1, 1'b0), 1'b0, 1'b1);
        push_item(FUNC_ENTRY, '0, '0, '1, 1'b1, 1'b1);
        // Entries while no walk is in flight are dropped.
        push_item(FUNC_ENTRY, '1, '1, '1, 1'b1, 1'b0);
        push_item(FUNC_ENTRY, '0, '0, 64'h1, 1'b0, 1'b0);
        // A start in the middle of a walk abandons it.
        push_item(FUNC_START, t_pa'(rand64()), t_va'(rand64()), '0, 1'b0, 1'b1);
        push_item(FUNC_ENTRY, '0, '0, build_entry(1'b1, 1'b0), 1'b0, 1'b1);
        push_item(FUNC_START, t_pa'(rand64()), t_va'(rand64()), '0, 1'b0, 1'b1);
        push_item(FUNC_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b1);

        // Random part in phases. The first phases use the extreme flag
        // positions, including both flags on the same bit.
        phase = 0;
        while (gen_count < TARGET_ITEMS) begin
            push_drain(phase % 4 == 2);
            case (phase)
                0: begin vsel = 6'd63; lsel = 6'd0;  end
                1: begin vsel = 6'd0;  lsel = 6'd63; end
                2: begin vsel = 6'd63; lsel = 6'd63; end
                3: begin vsel = 6'd0;  lsel = 6'd0;  end
                default: begin
                    vsel = t_bitpos'($urandom);
                    lsel = t_bitpos'($urandom);
                end
            endcase
            if (phase < 4 || $urandom_range(0, 2) != 0) begin
                push_reg(CFG_VALID_POS, vsel);
            end
            if (phase < 4 || $urandom_range(0, 2) != 0) begin
                push_reg(CFG_LARGE_POS, lsel);
            end
            walks = $urandom_range(10, 20);
            for (int w = 0; w < walks; w++) begin
                // Now and then some noise: random items of either kind.
                if ($urandom_range(0, 11) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        push_item(t_func'($urandom_range(0, 1)), t_pa'(rand64()),
                                  t_va'(rand64()), rand64(), 1'($urandom), 1'b1);
                    end
                end
                // Hold the sender off once in a while until all is delivered.
                if (w == walks / 2 && $urandom_range(0, 1) == 0) begin
                    push_drain(phase % 4 == 2);
                end
                add_walk();
            end
            phase++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: all block inputs change at the falling edge.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic       req_v;
        logic       cfg_v;
        t_stim_step s;
        if (i_rst_n) begin
            req_v = req_ch.valid;
            cfg_v = cfg_ch.valid;
            // Drop whatever transferred at the last rising edge.
            if (req_v && req_took) begin
                req_v = 1'b0;
            end
            if (cfg_v && cfg_took) begin
                cfg_v = 1'b0;
            end
            if (!req_v && !cfg_v) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (stim_steps.size() > 0) begin
                    s = stim_steps[0];
                    case (s.act)
                        ACT_ITEM: begin
                            req_v = 1'b1;
                            req_ch.func       <= s.item.func;
                            req_ch.root_addr  <= s.item.root_addr;
                            req_ch.virt_addr  <= s.item.virt_addr;
                            req_ch.entry      <= s.item.entry;
                            req_ch.read_error <= s.item.read_error;
                            void'(stim_steps.pop_front());
                            send_gap = pick_gap(steady);
                        end
                        ACT_REG: begin
                            // Registers change only once the walker is idle
                            // and any dropped entry has left the pipeline.
                            if (pending_walk_results.size() == 0 &&
                                quiet_cycles >= SETTLE_CYCLES) begin
                                cfg_v = 1'b1;
                                cfg_ch.index <= s.reg_idx;
                                cfg_ch.data  <= s.reg_val;
                                void'(stim_steps.pop_front());
                            end
                        end
                        default: begin
                            if (pending_walk_results.size() == 0) begin
                                steady = s.steady;
                                void'(stim_steps.pop_front());
                            end
                        end
                    endcase
                end
            end
            req_ch.valid <= req_v;
            cfg_ch.valid <= cfg_v;

            // The result side stalls on its own random schedule.
            if (rsp_stall > 0) begin
                rsp_stall--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    rsp_stall = pick_gap(steady);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: transfers are observed at the rising edge.
    // ------------------------------------------------------------------------
    task automatic report_field(input string fname, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        bit      has_result;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_walk_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
        req_took = 1'b0;
        cfg_took = 1'b0;
        if (i_rst_n) begin
            // A result at this edge always belongs to an earlier input
            // transfer, so it is checked before this edge's input is modeled.
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.kind        = rsp_ch.kind;
                got.read_addr   = rsp_ch.read_addr;
                got.phys_addr   = rsp_ch.phys_addr;
                got.fault_level = rsp_ch.fault_level;
                if (pending_walk_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    error_count++;
                end else begin
                    want = pending_walk_results.pop_front();
                    report_field("kind", 64'(want.kind), 64'(got.kind));
                    report_field("read_addr", 64'(want.read_addr), 64'(got.read_addr));
                    report_field("phys_addr", 64'(want.phys_addr), 64'(got.phys_addr));
                    report_field("fault_level", 64'(want.fault_level),
                                 64'(got.fault_level));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                req_took = 1'b1;
                has_result = predict_walk('{func: req_ch.func, root_addr: req_ch.root_addr,
                                            virt_addr: req_ch.virt_addr,
                                            entry: req_ch.entry,
                                            read_error: req_ch.read_error}, want);
                if (has_result) begin
                    pending_walk_results.push_back(want);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                cfg_took = 1'b1;
                if (cfg_ch.index == CFG_VALID_POS) begin
                    pos_valid = cfg_ch.data;
                end else if (cfg_ch.index == CFG_LARGE_POS) begin
                    pos_large = cfg_ch.data;
                end
            end
            if (pending_walk_results.size() == 0 && !req_ch.valid && !rsp_ch.valid) begin
                quiet_cycles++;
            end else begin
                quiet_cycles = 0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, run the script, drain, report.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.func       = FUNC_START;
        req_ch.root_addr  = '0;
        req_ch.virt_addr  = '0;
        req_ch.entry      = '0;
        req_ch.read_error = 1'b0;
        rsp_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_VALID_POS;
        cfg_ch.data       = '0;
        req_took          = 1'b0;
        cfg_took          = 1'b0;
        quiet_cycles      = 0;
        cycle_count       = 0;
        error_count       = 0;
        send_gap          = 0;
        rsp_stall         = 0;
        steady            = 1'b0;
        walk_busy         = 1'b0;
        walk_lvl          = LVL_TOP;
        walk_va           = '0;
        pos_valid         = VALID_POS_RST;
        pos_large         = LARGE_POS_RST;

        build_stimulus();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the whole script to transfer, then for the last results.
        @(posedge i_clk);
        while (stim_steps.size() != 0 || req_ch.valid || cfg_ch.valid) begin
            @(posedge i_clk);
        end
        while (pending_walk_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/pltw_pkg.sv
hdl/pltw_in_if.sv
hdl/pltw_out_if.sv
hdl/pltw_cfg_if.sv
hdl/pltw_cfg_regs.sv
hdl/pltw_step.sv
hdl/four_level_page_table_walker.sv
tb/four_level_page_table_walker_tb.sv
